FILE: sv/gest_pkg.sv
// Shared types, constants and helper functions for the gamepad edge-state tracker.
`default_nettype none

package gest_pkg;

  localparam int BTN_COUNT  = 14;
  localparam int STICKS     = 4;
  localparam int TRIGS      = 2;
  localparam int AXIS_COUNT = STICKS + TRIGS;
  localparam int BTN_W      = 2 * BTN_COUNT;
  localparam int AXIS_W     = 2 * AXIS_COUNT;
  localparam int MAX_PADS   = 4;  // pad field is two bits wide

  localparam int DZ_W  = 15;
  localparam int TRG_W = 8;
  localparam int STK_W = 16;
  localparam int CFG_W = 15;

  localparam logic [DZ_W-1:0]  LEFT_DZ_RESET  = 15'd7849;
  localparam logic [DZ_W-1:0]  RIGHT_DZ_RESET = 15'd8689;
  localparam logic [TRG_W-1:0] TRIG_TH_RESET  = 8'd30;

  localparam logic signed [STK_W-1:0] STICK_NEG_FULL  = 16'sh8000;
  localparam logic signed [STK_W-1:0] STICK_NEG_CLAMP = 16'sh8001;

  typedef enum logic [1:0] {
    TRK_RELEASED = 2'd0,
    TRK_JUST_ON  = 2'd1,
    TRK_ON       = 2'd2,
    TRK_JUST_OFF = 2'd3
  } trk_state_t;

  typedef enum logic [1:0] {
    CFG_LEFT_DZ  = 2'd0,
    CFG_RIGHT_DZ = 2'd1,
    CFG_TRIG_TH  = 2'd2
  } cfg_idx_t;

  // Bit of the raw button word that feeds tracker k (0x400 and 0x800 unused).
  function automatic logic [3:0] btn_bit(input int k);
    logic [3:0] b;
    b = 4'(k);
    if (k >= 10) begin
      b = 4'(k + 2);
    end
    return b;
  endfunction

  // Four-state edge tracker; a press seen while just released holds there.
  function automatic logic [1:0] advance(input logic [1:0] st, input logic on);
    logic [1:0] ns;
    ns = TRK_RELEASED;
    if (on) begin
      case (trk_state_t'(st))
        TRK_RELEASED: ns = TRK_JUST_ON;
        TRK_JUST_ON:  ns = TRK_ON;
        default:      ns = st;
      endcase
    end else begin
      case (trk_state_t'(st))
        TRK_JUST_ON, TRK_ON: ns = TRK_JUST_OFF;
        default:             ns = TRK_RELEASED;
      endcase
    end
    return ns;
  endfunction

  function automatic logic is_on(input logic [1:0] st);
    return (st == TRK_JUST_ON) || (st == TRK_ON);
  endfunction

endpackage

`default_nettype wire

FILE: sv/gamepad_edge_state_tracker.sv
// Gamepad edge-state tracker: per-pad button/axis trackers with dead zones.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | sink      | in_valid/in_stall  | pad, connected, button_bits, sticks, trigs
//  out     | source    | out_valid/out_stall| pad_out, active, states, stored values
//  cfg     | sink      | cfg_we             | cfg_index, cfg_data
//
// One word per cycle sustained while the result is not stalled; a word goes through
// the input register, then the per-pad read-modify-write into the result register.
// The pad state is a register file of up to four entries, updated in the same edge
// that loads the result, so back-to-back polls of one pad see each other's updates.
// Synchronous reset clears all trackers, stored values and active flags.
// A stalled result holds; the input register still fills while it is empty.
`default_nettype none

module gamepad_edge_state_tracker #(
  parameter int PADS = 4
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [1:0]                         pad,
  input  wire                                connected,
  input  wire  [15:0]                        button_bits,
  input  wire  signed [gest_pkg::STK_W-1:0]  left_x,
  input  wire  signed [gest_pkg::STK_W-1:0]  left_y,
  input  wire  signed [gest_pkg::STK_W-1:0]  right_x,
  input  wire  signed [gest_pkg::STK_W-1:0]  right_y,
  input  wire  [gest_pkg::TRG_W-1:0]         left_trig,
  input  wire  [gest_pkg::TRG_W-1:0]         right_trig,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [1:0]                         pad_out,
  output logic                               active,
  output logic [gest_pkg::BTN_W-1:0]         button_states,
  output logic [gest_pkg::AXIS_W-1:0]        axis_states,
  output logic signed [gest_pkg::STK_W-1:0]  lx_value,
  output logic signed [gest_pkg::STK_W-1:0]  ly_value,
  output logic signed [gest_pkg::STK_W-1:0]  rx_value,
  output logic signed [gest_pkg::STK_W-1:0]  ry_value,
  output logic [gest_pkg::TRG_W-1:0]         lt_value,
  output logic [gest_pkg::TRG_W-1:0]         rt_value,
  input  wire                                cfg_we,
  input  wire  [1:0]                         cfg_index,
  input  wire  [gest_pkg::CFG_W-1:0]         cfg_data
);

  // only pads the two-bit field can name get storage
  localparam int DEPTH = (PADS < gest_pkg::MAX_PADS) ? PADS : gest_pkg::MAX_PADS;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [2:0] DEPTH_L = 3'(DEPTH);

  // configuration
  logic [gest_pkg::DZ_W-1:0]  left_dz;
  logic [gest_pkg::DZ_W-1:0]  right_dz;
  logic [gest_pkg::TRG_W-1:0] trig_th;

  // input register
  logic                              s1_valid;
  logic [1:0]                        s1_pad;
  logic                              s1_conn;
  logic [15:0]                       s1_bits;
  logic signed [gest_pkg::STK_W-1:0] s1_stick [gest_pkg::STICKS];
  logic [gest_pkg::TRG_W-1:0]        s1_trig  [gest_pkg::TRIGS];

  // per-pad state
  logic [gest_pkg::BTN_W-1:0]        btn_trk     [DEPTH];
  logic [gest_pkg::AXIS_W-1:0]       axis_trk    [DEPTH];
  logic signed [gest_pkg::STK_W-1:0] stick_val   [DEPTH][gest_pkg::STICKS];
  logic [gest_pkg::TRG_W-1:0]        trig_val    [DEPTH][gest_pkg::TRIGS];
  logic                              active_flag [DEPTH];

  logic                              s1_go;
  logic                              in_range;
  logic [IW-1:0]                     idx;
  logic [gest_pkg::BTN_W-1:0]        btn_next;
  logic [gest_pkg::AXIS_W-1:0]       axis_next;
  logic signed [gest_pkg::STK_W-1:0] stick_next [gest_pkg::STICKS];
  logic [gest_pkg::TRG_W-1:0]        trig_next  [gest_pkg::TRIGS];

  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_range = {1'b0, s1_pad} < DEPTH_L;
  assign idx      = IW'(s1_pad);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= gest_pkg::LEFT_DZ_RESET;
      right_dz <= gest_pkg::RIGHT_DZ_RESET;
      trig_th  <= gest_pkg::TRIG_TH_RESET;
    end else if (cfg_we) begin
      unique case (gest_pkg::cfg_idx_t'(cfg_index))
        gest_pkg::CFG_LEFT_DZ:  left_dz  <= cfg_data;
        gest_pkg::CFG_RIGHT_DZ: right_dz <= cfg_data;
        gest_pkg::CFG_TRIG_TH:  trig_th  <= cfg_data[gest_pkg::TRG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_pad      <= pad;
      s1_conn     <= connected;
      s1_bits     <= button_bits;
      s1_stick[0] <= left_x;
      s1_stick[1] <= left_y;
      s1_stick[2] <= right_x;
      s1_stick[3] <= right_y;
      s1_trig[0]  <= left_trig;
      s1_trig[1]  <= right_trig;
    end
  end

  always_comb begin
    logic [gest_pkg::BTN_W-1:0]  cur_btn;
    logic [gest_pkg::AXIS_W-1:0] cur_axis;
    logic signed [16:0]          r17;
    logic signed [16:0]          dz17;
    logic                        moved;
    logic [1:0]                  st;
    cur_btn  = btn_trk[idx];
    cur_axis = axis_trk[idx];
    btn_next  = '0;
    axis_next = '0;
    for (int k = 0; k < gest_pkg::BTN_COUNT; k++) begin
      btn_next[2*k +: 2] = gest_pkg::advance(cur_btn[2*k +: 2],
                                             s1_bits[gest_pkg::btn_bit(k)]);
    end
    for (int k = 0; k < gest_pkg::STICKS; k++) begin
      r17   = {s1_stick[k][gest_pkg::STK_W-1], s1_stick[k]};
      dz17  = {2'b00, ((k < 2) ? left_dz : right_dz)};
      moved = (r17 > dz17) || (r17 < -dz17);
      st    = cur_axis[2*k +: 2];
      axis_next[2*k +: 2] = gest_pkg::advance(st, moved);
      if (moved) begin
        stick_next[k] = (s1_stick[k] == gest_pkg::STICK_NEG_FULL) ?
                        gest_pkg::STICK_NEG_CLAMP : s1_stick[k];
      end else if (gest_pkg::is_on(st)) begin
        stick_next[k] = '0;
      end else begin
        stick_next[k] = stick_val[idx][k];
      end
    end
    for (int k = 0; k < gest_pkg::TRIGS; k++) begin
      moved = s1_trig[k] > trig_th;
      st    = cur_axis[2*(k + gest_pkg::STICKS) +: 2];
      axis_next[2*(k + gest_pkg::STICKS) +: 2] = gest_pkg::advance(st, moved);
      if (moved) begin
        trig_next[k] = s1_trig[k];
      end else if (gest_pkg::is_on(st)) begin
        trig_next[k] = '0;
      end else begin
        trig_next[k] = trig_val[idx][k];
      end
    end
    // a disconnected poll leaves everything but the active flag alone
    if (!s1_conn) begin
      btn_next  = cur_btn;
      axis_next = cur_axis;
      for (int k = 0; k < gest_pkg::STICKS; k++) begin
        stick_next[k] = stick_val[idx][k];
      end
      for (int k = 0; k < gest_pkg::TRIGS; k++) begin
        trig_next[k] = trig_val[idx][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < DEPTH; p++) begin
        btn_trk[p]     <= '0;
        axis_trk[p]    <= '0;
        active_flag[p] <= 1'b0;
        for (int k = 0; k < gest_pkg::STICKS; k++) begin
          stick_val[p][k] <= '0;
        end
        for (int k = 0; k < gest_pkg::TRIGS; k++) begin
          trig_val[p][k] <= '0;
        end
      end
    end else if (s1_go && in_range) begin
      active_flag[idx] <= s1_conn;
      btn_trk[idx]     <= btn_next;
      axis_trk[idx]    <= axis_next;
      for (int k = 0; k < gest_pkg::STICKS; k++) begin
        stick_val[idx][k] <= stick_next[k];
      end
      for (int k = 0; k < gest_pkg::TRIGS; k++) begin
        trig_val[idx][k] <= trig_next[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_go) begin
      pad_out <= s1_pad;
      if (in_range) begin
        active        <= s1_conn;
        button_states <= btn_next;
        axis_states   <= axis_next;
        lx_value      <= stick_next[0];
        ly_value      <= stick_next[1];
        rx_value      <= stick_next[2];
        ry_value      <= stick_next[3];
        lt_value      <= trig_next[0];
        rt_value      <= trig_next[1];
      end else begin
        active        <= 1'b0;
        button_states <= '0;
        axis_states   <= '0;
        lx_value      <= '0;
        ly_value      <= '0;
        rx_value      <= '0;
        ry_value      <= '0;
        lt_value      <= '0;
        rt_value      <= '0;
      end
    end
  end

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_result_tracks_word: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_valid && pad_out == $past(s1_pad) &&
              active == $past(s1_conn && in_range))
    else $error("result does not match the word that entered it");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    s1_go && in_range |=> button_states == btn_trk[$past(idx)] &&
                          axis_states == axis_trk[$past(idx)])
    else $error("result and stored trackers disagree");

  a_unknown_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({1'b0, pad_out} >= DEPTH_L) |->
      !active && button_states == '0 && axis_states == '0 &&
      lx_value == '0 && ry_value == '0 && lt_value == '0 && rt_value == '0)
    else $error("result for a pad without storage is not zero");

endmodule

`default_nettype wire
